// ===== hdl/smau_pkg.sv =====
package smau_pkg;

  // Vector geometry and value format.
  localparam int VEC_DEPTH = 1024;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;

  // Unity in the Q1.24 coefficient format.
  localparam logic [24:0] ONE_Q24 = 25'd16777216;

  // Register reset values.
  localparam logic [23:0] LR_RESET    = 24'd167772;
  localparam logic [16:0] MOM_RESET   = 17'd58982;
  localparam logic [16:0] MOM_ONE     = 17'd65536;
  localparam logic [24:0] BETA1_RESET = 25'd15099494;
  localparam logic [24:0] BETA2_RESET = 25'd16760439;
  localparam logic [31:0] EPS_RESET   = 32'd43;

  // Divider geometry: 64-bit dividend, 32-bit quotient with overflow flag.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 42;
  localparam int DIV_Q_W   = 32;

  // Square root geometry.
  localparam int SQRT_X_W    = 64;
  localparam int SQRT_ROOT_W = 32;

  typedef enum logic [2:0] {
    CFG_LEARNING_RATE = 3'd0,
    CFG_MOMENTUM      = 3'd1,
    CFG_ADAM_ENABLE   = 3'd2,
    CFG_BETA_FIRST    = 3'd3,
    CFG_BETA_SECOND   = 3'd4,
    CFG_EPSILON       = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_GRAD = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SV_MUL1,
    ST_SV_MUL2,
    ST_SV_VEL,
    ST_SV_PAR,
    ST_AD_POW1,
    ST_AD_POW2,
    ST_AD_POW3,
    ST_AD_M1,
    ST_AD_M2,
    ST_AD_M3,
    ST_AD_GSQ,
    ST_AD_S1,
    ST_AD_S2,
    ST_AD_S3,
    ST_AD_MH_GO,
    ST_AD_MH_WAIT,
    ST_AD_VH_GO,
    ST_AD_VH_WAIT,
    ST_AD_RT_GO,
    ST_AD_RT_WAIT,
    ST_AD_NUM1,
    ST_AD_NUM2,
    ST_AD_Q_WAIT,
    ST_AD_PAR
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               overflow;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [SQRT_X_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                   done;
    logic [SQRT_ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== hdl/smau_ram.sv =====
module smau_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/smau_div.sv =====
module smau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  smau_pkg::div_req_t req,
  output smau_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(smau_pkg::DIV_Q_W);
  localparam int HI_W  = smau_pkg::DIV_NUM_W - smau_pkg::DIV_Q_W;

  logic [smau_pkg::DIV_DEN_W-1:0] rem_r;
  logic [smau_pkg::DIV_DEN_W-1:0] den_r;
  logic [smau_pkg::DIV_Q_W-1:0]   quo_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic                           ovf_r;

  logic [smau_pkg::DIV_DEN_W-1:0] hi_ext;
  logic [smau_pkg::DIV_DEN_W:0]   trial;
  logic [smau_pkg::DIV_DEN_W:0]   diff;
  logic                           fits;

  // Upper dividend half seeds the remainder; if it already reaches the
  // divisor the quotient does not fit in the result width.
  assign hi_ext = {{(smau_pkg::DIV_DEN_W - HI_W){1'b0}},
                   req.dividend[smau_pkg::DIV_NUM_W-1 -: HI_W]};
  assign trial  = {rem_r, quo_r[smau_pkg::DIV_Q_W-1]};
  assign diff   = trial - {1'b0, den_r};
  assign fits   = (trial >= {1'b0, den_r});

  // Control: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (hi_ext >= req.divisor) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Restoring shift-subtract datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.divisor;
      rem_r <= hi_ext;
      quo_r <= req.dividend[smau_pkg::DIV_Q_W-1:0];
      cnt_r <= CNT_W'(smau_pkg::DIV_Q_W - 1);
      ovf_r <= (hi_ext >= req.divisor);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= diff[smau_pkg::DIV_DEN_W-1:0];
      end else begin
        rem_r <= trial[smau_pkg::DIV_DEN_W-1:0];
      end
      quo_r <= {quo_r[smau_pkg::DIV_Q_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.overflow = ovf_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hdl/smau_sqrt.sv =====
module smau_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  smau_pkg::sqrt_req_t req,
  output smau_pkg::sqrt_rsp_t rsp
);

  localparam int CNT_W = $clog2(smau_pkg::SQRT_ROOT_W);
  localparam int REM_W = smau_pkg::SQRT_ROOT_W + 4;

  logic [smau_pkg::SQRT_X_W-1:0]    xs_r;
  logic [REM_W-1:0]                 rem_r;
  logic [smau_pkg::SQRT_ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             busy_r;
  logic                             done_r;

  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down two radicand bits and try appending a one to the root.
  assign cur   = {rem_r[REM_W-3:0], xs_r[smau_pkg::SQRT_X_W-1 -: 2]};
  assign trial = {{(REM_W - smau_pkg::SQRT_ROOT_W - 2){1'b0}}, root_r, 2'b01};
  assign fits  = (cur >= trial);

  // Control: one root bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Restoring digit-by-digit square root.
  always_ff @(posedge clk) begin
    if (req.start) begin
      xs_r   <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(smau_pkg::SQRT_ROOT_W - 1);
    end else if (busy_r) begin
      xs_r   <= {xs_r[smau_pkg::SQRT_X_W-3:0], 2'b00};
      rem_r  <= fits ? (cur - trial) : cur;
      root_r <= {root_r[smau_pkg::SQRT_ROOT_W-2:0], fits};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ===== hdl/sgd_momentum_adam_update_top.sv =====
// Per-element optimizer update engine, SGD with momentum or Adam, Q16.16.
// Input channel: present in_command, in_index and in_value with start high;
// the item transfers at a clock edge where start is high and busy is low.
// A load command writes the parameter, clears velocity and both moments of
// that element and resets both bias-correction powers to one.
// A gradient command runs one update under a small sequencer: a shared
// 33x33 multiplier and, for Adam, a bit-serial divider and square root.
// Result channel: out_valid is high for exactly one cycle with out_index,
// out_param_out and out_saturated; the receiver cannot hold it off.
// A load answers in the cycle after its transfer and busy never rises.
// An SGD gradient steps through SV_MUL1, SV_MUL2, SV_VEL and SV_PAR. An Adam
// gradient is dominated by four bit-serial runs (two bias divisions, the
// square root and the step division, one bit per cycle); index 0 adds the
// power update, a unity bias power skips the units and a division whose
// quotient overflows ends early.
// Configuration: cfg_we, cfg_index and cfg_data write one register per
// cycle. Write only while the block is idle; the block does not check it.
// Reset (rst_n low, synchronous) returns registers to their defaults and
// the powers to one; the element memories are not cleared.
module sgd_momentum_adam_update_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [9:0]  in_index,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [9:0]  out_index,
  output logic signed [31:0] out_param_out,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Sequencer state.
  smau_pkg::state_t state_r;
  smau_pkg::state_t state_nxt;

  // Configuration registers and bias-correction powers.
  logic [23:0] lr_r;
  logic [16:0] mom_r;
  logic        adam_r;
  logic [24:0] b1_r;
  logic [24:0] b2_r;
  logic [31:0] eps_r;
  logic [24:0] bp1_r;
  logic [24:0] bp2_r;

  // Item and working registers.
  logic [9:0]         idx_r;
  logic signed [31:0] val_r;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [31:0] v_r;
  logic signed [31:0] m_r;
  logic [31:0]        gsq_r;
  logic [31:0]        s_r;
  logic signed [31:0] mhat_r;
  logic [31:0]        vhat_r;
  logic [41:0]        den_r;
  logic signed [31:0] step_r;
  logic               sat_r;

  // Result registers.
  logic               out_valid_r;
  logic [9:0]         out_index_r;
  logic signed [31:0] out_param_r;
  logic               out_sat_r;

  // Element memories.
  logic [31:0] param_rd;
  logic [31:0] vel_rd;
  logic [31:0] m_rd;
  logic [31:0] s_rd;
  logic        param_we;
  logic        vel_we;
  logic        mom1_we;
  logic        mom2_we;
  logic [9:0]  mem_waddr;
  logic [31:0] param_wd;
  logic [31:0] vel_wd;
  logic [31:0] mom1_wd;
  logic [31:0] mom2_wd;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  // Iterative units.
  smau_pkg::div_req_t  div_req;
  smau_pkg::div_rsp_t  div_rsp;
  smau_pkg::sqrt_req_t sqrt_req;
  smau_pkg::sqrt_rsp_t sqrt_rsp;

  // Combinational helpers.
  logic               accept;
  logic               is_load;
  logic [32:0]        gmag;
  logic [24:0]        one_m_b1;
  logic [24:0]        one_m_b2;
  logic [24:0]        d1;
  logic [24:0]        d2;
  logic signed [65:0] sgd_diff;
  logic signed [65:0] sgd_v;
  logic [32:0]        sgd_vc;
  logic signed [32:0] sgd_psum;
  logic [32:0]        sgd_pc;
  logic signed [32:0] ad_psum;
  logic [32:0]        ad_pc;
  logic signed [65:0] ad_sum;
  logic [31:0]        m_mag;
  logic [31:0]        mhat_mag;
  logic [32:0]        mhat_sat;
  logic [32:0]        q_sat;
  logic [41:0]        den_new;

  function automatic logic [32:0] clamp_s32(input logic signed [65:0] x);
    logic [32:0] r;
    if (x > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (x < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // Signed value from sign and magnitude, clamped to 32 bits.
  function automatic logic [32:0] sign_sat(input logic neg, input logic [32:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 33'h0_8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - mag[31:0]};
      end
    end else begin
      if (mag > 33'h0_7FFF_FFFF) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, mag[31:0]};
      end
    end
    return r;
  endfunction

  // Largest step with the sign of the source, zero for a zero source.
  function automatic logic [31:0] extreme(input logic signed [31:0] x);
    logic [31:0] r;
    if (x > 32'sd0) begin
      r = 32'h7FFF_FFFF;
    end else if (x < 32'sd0) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'd0;
    end
    return r;
  endfunction

  assign busy    = (state_r != smau_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign is_load = (in_command == smau_pkg::CMD_LOAD);

  assign gmag     = val_r[31] ? (33'd0 - {val_r[31], val_r}) : {1'b0, val_r};
  assign one_m_b1 = smau_pkg::ONE_Q24 - b1_r;
  assign one_m_b2 = smau_pkg::ONE_Q24 - b2_r;
  assign d1       = smau_pkg::ONE_Q24 - bp1_r;
  assign d2       = smau_pkg::ONE_Q24 - bp2_r;

  // SGD velocity and parameter.
  assign sgd_diff = acc_r - prod_r;
  assign sgd_v    = sgd_diff >>> 24;
  assign sgd_vc   = clamp_s32(sgd_v);
  assign sgd_psum = {param_rd[31], param_rd} + {v_r[31], v_r};
  assign sgd_pc   = clamp_s32({{33{sgd_psum[32]}}, sgd_psum});

  // Adam moments, step and parameter.
  assign ad_sum   = acc_r + prod_r;
  assign m_mag    = abs32(m_r);
  assign mhat_mag = abs32(mhat_r);
  assign mhat_sat = sign_sat(m_r[31],
                             div_rsp.overflow ? {33{1'b1}} : {1'b0, div_rsp.quotient});
  assign q_sat    = sign_sat(mhat_r[31],
                             div_rsp.overflow ? {33{1'b1}} : {1'b0, div_rsp.quotient});
  assign den_new  = {2'b00, sqrt_rsp.root, 8'd0} + {10'd0, eps_r};
  assign ad_psum  = {param_rd[31], param_rd} - {step_r[31], step_r};
  assign ad_pc    = clamp_s32({{33{ad_psum[32]}}, ad_psum});

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Configuration writes and bias-correction powers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= smau_pkg::LR_RESET;
      mom_r  <= smau_pkg::MOM_RESET;
      adam_r <= 1'b0;
      b1_r   <= smau_pkg::BETA1_RESET;
      b2_r   <= smau_pkg::BETA2_RESET;
      eps_r  <= smau_pkg::EPS_RESET;
      bp1_r  <= smau_pkg::ONE_Q24;
      bp2_r  <= smau_pkg::ONE_Q24;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          smau_pkg::CFG_LEARNING_RATE: begin
            lr_r <= (cfg_data[23:0] == 24'd0) ? 24'd1 : cfg_data[23:0];
          end
          smau_pkg::CFG_MOMENTUM: begin
            mom_r <= (cfg_data[16:0] > smau_pkg::MOM_ONE) ? smau_pkg::MOM_ONE
                                                           : cfg_data[16:0];
          end
          smau_pkg::CFG_ADAM_ENABLE: begin
            adam_r <= cfg_data[0];
          end
          smau_pkg::CFG_BETA_FIRST: begin
            b1_r <= (cfg_data[24:0] > smau_pkg::ONE_Q24) ? smau_pkg::ONE_Q24
                                                          : cfg_data[24:0];
          end
          smau_pkg::CFG_BETA_SECOND: begin
            b2_r <= (cfg_data[24:0] > smau_pkg::ONE_Q24) ? smau_pkg::ONE_Q24
                                                          : cfg_data[24:0];
          end
          smau_pkg::CFG_EPSILON: begin
            eps_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (accept && is_load) begin
        bp1_r <= smau_pkg::ONE_Q24;
        bp2_r <= smau_pkg::ONE_Q24;
      end else if (state_r == smau_pkg::ST_AD_POW2) begin
        bp1_r <= prod_r[48:24];
      end else if (state_r == smau_pkg::ST_AD_POW3) begin
        bp2_r <= prod_r[48:24];
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smau_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smau_pkg::ST_IDLE: begin
        if (accept && !is_load) begin
          if (!adam_r) begin
            state_nxt = smau_pkg::ST_SV_MUL1;
          end else if (in_index == 10'd0) begin
            state_nxt = smau_pkg::ST_AD_POW1;
          end else begin
            state_nxt = smau_pkg::ST_AD_M1;
          end
        end
      end
      smau_pkg::ST_SV_MUL1:  state_nxt = smau_pkg::ST_SV_MUL2;
      smau_pkg::ST_SV_MUL2:  state_nxt = smau_pkg::ST_SV_VEL;
      smau_pkg::ST_SV_VEL:   state_nxt = smau_pkg::ST_SV_PAR;
      smau_pkg::ST_SV_PAR:   state_nxt = smau_pkg::ST_IDLE;
      smau_pkg::ST_AD_POW1:  state_nxt = smau_pkg::ST_AD_POW2;
      smau_pkg::ST_AD_POW2:  state_nxt = smau_pkg::ST_AD_POW3;
      smau_pkg::ST_AD_POW3:  state_nxt = smau_pkg::ST_AD_M1;
      smau_pkg::ST_AD_M1:    state_nxt = smau_pkg::ST_AD_M2;
      smau_pkg::ST_AD_M2:    state_nxt = smau_pkg::ST_AD_M3;
      smau_pkg::ST_AD_M3:    state_nxt = smau_pkg::ST_AD_GSQ;
      smau_pkg::ST_AD_GSQ:   state_nxt = smau_pkg::ST_AD_S1;
      smau_pkg::ST_AD_S1:    state_nxt = smau_pkg::ST_AD_S2;
      smau_pkg::ST_AD_S2:    state_nxt = smau_pkg::ST_AD_S3;
      smau_pkg::ST_AD_S3:    state_nxt = smau_pkg::ST_AD_MH_GO;
      smau_pkg::ST_AD_MH_GO: begin
        if (d1 == 25'd0 || d2 == 25'd0) begin
          state_nxt = smau_pkg::ST_AD_PAR;
        end else begin
          state_nxt = smau_pkg::ST_AD_MH_WAIT;
        end
      end
      smau_pkg::ST_AD_MH_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = smau_pkg::ST_AD_VH_GO;
        end
      end
      smau_pkg::ST_AD_VH_GO: state_nxt = smau_pkg::ST_AD_VH_WAIT;
      smau_pkg::ST_AD_VH_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = smau_pkg::ST_AD_RT_GO;
        end
      end
      smau_pkg::ST_AD_RT_GO: state_nxt = smau_pkg::ST_AD_RT_WAIT;
      smau_pkg::ST_AD_RT_WAIT: begin
        if (sqrt_rsp.done) begin
          state_nxt = smau_pkg::ST_AD_NUM1;
        end
      end
      smau_pkg::ST_AD_NUM1: begin
        if (den_r == 42'd0) begin
          state_nxt = smau_pkg::ST_AD_PAR;
        end else begin
          state_nxt = smau_pkg::ST_AD_NUM2;
        end
      end
      smau_pkg::ST_AD_NUM2: state_nxt = smau_pkg::ST_AD_Q_WAIT;
      smau_pkg::ST_AD_Q_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = smau_pkg::ST_AD_PAR;
        end
      end
      smau_pkg::ST_AD_PAR:   state_nxt = smau_pkg::ST_IDLE;
      default:               state_nxt = smau_pkg::ST_IDLE;
    endcase
  end

  // Per-state outputs: multiplier operands, unit requests, memory writes.
  always_comb begin
    mul_a             = '0;
    mul_b             = '0;
    div_req.start     = 1'b0;
    div_req.dividend  = '0;
    div_req.divisor   = '0;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = {vhat_r, 32'd0};
    param_we          = 1'b0;
    vel_we            = 1'b0;
    mom1_we           = 1'b0;
    mom2_we           = 1'b0;
    mem_waddr         = idx_r;
    param_wd          = in_value;
    vel_wd            = 32'd0;
    mom1_wd           = 32'd0;
    mom2_wd           = 32'd0;
    case (state_r)
      smau_pkg::ST_IDLE: begin
        if (accept && is_load) begin
          param_we  = 1'b1;
          vel_we    = 1'b1;
          mom1_we   = 1'b1;
          mom2_we   = 1'b1;
          mem_waddr = in_index;
        end
      end
      smau_pkg::ST_SV_MUL1: begin
        mul_a = {16'd0, mom_r};
        mul_b = {vel_rd[31], vel_rd};
      end
      smau_pkg::ST_SV_MUL2: begin
        mul_a = {9'd0, lr_r};
        mul_b = {val_r[31], val_r};
      end
      smau_pkg::ST_SV_PAR: begin
        param_we = 1'b1;
        vel_we   = 1'b1;
        param_wd = sgd_pc[31:0];
        vel_wd   = v_r;
      end
      smau_pkg::ST_AD_POW1: begin
        mul_a = {8'd0, bp1_r};
        mul_b = {8'd0, b1_r};
      end
      smau_pkg::ST_AD_POW2: begin
        mul_a = {8'd0, bp2_r};
        mul_b = {8'd0, b2_r};
      end
      smau_pkg::ST_AD_M1: begin
        mul_a = {8'd0, b1_r};
        mul_b = {m_rd[31], m_rd};
      end
      smau_pkg::ST_AD_M2: begin
        mul_a = {8'd0, one_m_b1};
        mul_b = {val_r[31], val_r};
      end
      smau_pkg::ST_AD_M3: begin
        mul_a = gmag;
        mul_b = gmag;
      end
      smau_pkg::ST_AD_S1: begin
        mul_a = {8'd0, b2_r};
        mul_b = {1'b0, s_rd};
      end
      smau_pkg::ST_AD_S2: begin
        mul_a = {8'd0, one_m_b2};
        mul_b = {1'b0, gsq_r};
      end
      smau_pkg::ST_AD_MH_GO: begin
        if (d1 != 25'd0 && d2 != 25'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, m_mag, 24'd0};
          div_req.divisor  = {17'd0, d1};
        end
      end
      smau_pkg::ST_AD_VH_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'd0, s_r, 24'd0};
        div_req.divisor  = {17'd0, d2};
      end
      smau_pkg::ST_AD_RT_GO: begin
        sqrt_req.start = 1'b1;
      end
      smau_pkg::ST_AD_NUM1: begin
        mul_a = {9'd0, lr_r};
        mul_b = {1'b0, mhat_mag};
      end
      smau_pkg::ST_AD_NUM2: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod_r[55:0], 8'd0};
        div_req.divisor  = den_r;
      end
      smau_pkg::ST_AD_PAR: begin
        param_we = 1'b1;
        mom1_we  = 1'b1;
        mom2_we  = 1'b1;
        param_wd = ad_pc[31:0];
        mom1_wd  = m_r;
        mom2_wd  = s_r;
      end
      default: begin
      end
    endcase
  end

  // Working registers along the update sequence.
  always_ff @(posedge clk) begin
    case (state_r)
      smau_pkg::ST_IDLE: begin
        if (accept) begin
          idx_r <= in_index;
          val_r <= in_value;
          sat_r <= 1'b0;
        end
      end
      smau_pkg::ST_SV_MUL2: acc_r <= prod_r <<< 8;
      smau_pkg::ST_SV_VEL: begin
        v_r   <= sgd_vc[31:0];
        sat_r <= sat_r | sgd_vc[32];
      end
      smau_pkg::ST_AD_M2: acc_r <= prod_r;
      smau_pkg::ST_AD_M3: m_r   <= ad_sum[55:24];
      smau_pkg::ST_AD_GSQ: begin
        if (prod_r[65:48] != 18'd0) begin
          gsq_r <= 32'hFFFF_FFFF;
          sat_r <= 1'b1;
        end else begin
          gsq_r <= prod_r[47:16];
        end
      end
      smau_pkg::ST_AD_S2: acc_r <= prod_r;
      smau_pkg::ST_AD_S3: s_r   <= ad_sum[55:24];
      smau_pkg::ST_AD_MH_GO: begin
        if (d1 == 25'd0 || d2 == 25'd0) begin
          step_r <= extreme(m_r);
          sat_r  <= 1'b1;
        end
      end
      smau_pkg::ST_AD_MH_WAIT: begin
        if (div_rsp.done) begin
          mhat_r <= mhat_sat[31:0];
          sat_r  <= sat_r | mhat_sat[32];
        end
      end
      smau_pkg::ST_AD_VH_WAIT: begin
        if (div_rsp.done) begin
          vhat_r <= div_rsp.overflow ? 32'hFFFF_FFFF : div_rsp.quotient;
          sat_r  <= sat_r | div_rsp.overflow;
        end
      end
      smau_pkg::ST_AD_RT_WAIT: begin
        if (sqrt_rsp.done) begin
          den_r <= den_new;
        end
      end
      smau_pkg::ST_AD_NUM1: begin
        if (den_r == 42'd0) begin
          step_r <= (mhat_r == 32'sd0) ? 32'd0 : extreme(mhat_r);
          sat_r  <= sat_r | (mhat_r != 32'sd0);
        end
      end
      smau_pkg::ST_AD_Q_WAIT: begin
        if (div_rsp.done) begin
          step_r <= q_sat[31:0];
          sat_r  <= sat_r | q_sat[32];
        end
      end
      default: begin
      end
    endcase
  end

  // Result strobe: one cycle per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && is_load) ||
                     (state_r == smau_pkg::ST_SV_PAR) ||
                     (state_r == smau_pkg::ST_AD_PAR);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      out_index_r <= in_index;
      out_param_r <= in_value;
      out_sat_r   <= 1'b0;
    end else if (state_r == smau_pkg::ST_SV_PAR) begin
      out_index_r <= idx_r;
      out_param_r <= sgd_pc[31:0];
      out_sat_r   <= sat_r | sgd_pc[32];
    end else if (state_r == smau_pkg::ST_AD_PAR) begin
      out_index_r <= idx_r;
      out_param_r <= ad_pc[31:0];
      out_sat_r   <= sat_r | ad_pc[32];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_param_out = out_param_r;
  assign out_saturated = out_sat_r;

  // Element stores, all read at the accepted index.
  smau_ram #(.DEPTH(smau_pkg::VEC_DEPTH), .WIDTH(smau_pkg::VAL_W)) u_param_ram (
    .clk   (clk),
    .we    (param_we),
    .waddr (mem_waddr),
    .wdata (param_wd),
    .re    (accept),
    .raddr (in_index),
    .rdata (param_rd)
  );

  smau_ram #(.DEPTH(smau_pkg::VEC_DEPTH), .WIDTH(smau_pkg::VAL_W)) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (mem_waddr),
    .wdata (vel_wd),
    .re    (accept),
    .raddr (in_index),
    .rdata (vel_rd)
  );

  smau_ram #(.DEPTH(smau_pkg::VEC_DEPTH), .WIDTH(smau_pkg::VAL_W)) u_mom1_ram (
    .clk   (clk),
    .we    (mom1_we),
    .waddr (mem_waddr),
    .wdata (mom1_wd),
    .re    (accept),
    .raddr (in_index),
    .rdata (m_rd)
  );

  smau_ram #(.DEPTH(smau_pkg::VEC_DEPTH), .WIDTH(smau_pkg::VAL_W)) u_mom2_ram (
    .clk   (clk),
    .we    (mom2_we),
    .waddr (mem_waddr),
    .wdata (mom2_wd),
    .re    (accept),
    .raddr (in_index),
    .rdata (s_rd)
  );

  // Shared divider for both bias corrections and the final step.
  smau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Square root of the corrected second moment.
  smau_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

endmodule

// ===== test/sgd_momentum_adam_update_top_tb.sv =====
module sgd_momentum_adam_update_top_tb;

  localparam longint Q24_ONE = 64'd16777216;
  localparam longint S32_HI  = 64'sd2147483647;
  localparam longint S32_LO  = -64'sd2147483648;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [9:0]  in_index;
  logic signed [31:0] in_value;
  logic        out_valid;
  logic [9:0]  out_index;
  logic signed [31:0] out_param_out;
  logic        out_saturated;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  sgd_momentum_adam_update_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_index(out_index), .out_param_out(out_param_out),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [9:0]  idx;
    logic [31:0] par;
    logic        sat;
  } update_t;

  // Expected updates in arrival order.
  update_t pending_updates[$];
  update_t want;
  int      mismatches;
  int      sender_idle_pct;

  // Shadow copy of the optimizer state and registers.
  int          par_mem[smau_pkg::VEC_DEPTH];
  int          vel_mem[smau_pkg::VEC_DEPTH];
  int          m1_mem[smau_pkg::VEC_DEPTH];
  int unsigned m2_mem[smau_pkg::VEC_DEPTH];
  bit          loaded[smau_pkg::VEC_DEPTH];
  longint      pow1, pow2;
  longint      lr_reg, mom_reg, adam_reg, b1_reg, b2_reg, eps_reg;
  bit          upd_sat;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("sgd_momentum_adam_update_top test failed");
    $finish;
  end

  function automatic longint clamp32(longint x);
    if (x > S32_HI) begin
      upd_sat = 1'b1;
      return S32_HI;
    end
    if (x < S32_LO) begin
      upd_sat = 1'b1;
      return S32_LO;
    end
    return x;
  endfunction

  // Signed result from sign and magnitude, clamped to 32 bits.
  function automatic longint from_mag(bit neg, longint unsigned mag);
    if (neg) begin
      if (mag > 64'd2147483648) begin
        upd_sat = 1'b1;
        mag = 64'd2147483648;
      end
      return -longint'(mag);
    end
    if (mag > 64'd2147483647) begin
      upd_sat = 1'b1;
      mag = 64'd2147483647;
    end
    return longint'(mag);
  endfunction

  function automatic longint extreme(longint src);
    upd_sat = 1'b1;
    if (src > 0) return S32_HI;
    if (src < 0) return S32_LO;
    return 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag64(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // Adam step size for one element; updates both moments.
  function automatic longint adam_step(int idx, longint g);
    longint m, mhat;
    longint unsigned gsq, s, vhat, root, den, num, d1, d2;
    m = (b1_reg * longint'(m1_mem[idx]) + (Q24_ONE - b1_reg) * g) >>> 24;
    m1_mem[idx] = int'(m);
    gsq = (mag64(g) * mag64(g)) >> 16;
    if (gsq > 64'hFFFFFFFF) begin
      upd_sat = 1'b1;
      gsq = 64'hFFFFFFFF;
    end
    s = (unsigned'(b2_reg) * m2_mem[idx]
         + unsigned'(Q24_ONE - b2_reg) * gsq) >> 24;
    m2_mem[idx] = s[31:0];
    d1 = Q24_ONE - pow1;
    d2 = Q24_ONE - pow2;
    if (d1 == 0 || d2 == 0) return extreme(m);
    mhat = from_mag(m < 0, (mag64(m) << 24) / d1);
    vhat = (s << 24) / d2;
    if (vhat > 64'hFFFFFFFF) begin
      upd_sat = 1'b1;
      vhat = 64'hFFFFFFFF;
    end
    root = int_sqrt(vhat << 32);
    den = (root << 8) + unsigned'(eps_reg);
    if (den == 0) return (mhat == 0) ? 0 : extreme(mhat);
    num = (unsigned'(lr_reg) * mag64(mhat)) << 8;
    return from_mag(mhat < 0, num / den);
  endfunction

  // Work out the result of one transferred command and update the shadow state.
  function automatic update_t predict_update(smau_pkg::cmd_t cmd, int idx, longint val);
    update_t u;
    longint p, v;
    upd_sat = 1'b0;
    if (cmd == smau_pkg::CMD_LOAD) begin
      par_mem[idx] = int'(val);
      vel_mem[idx] = 0;
      m1_mem[idx] = 0;
      m2_mem[idx] = 0;
      pow1 = Q24_ONE;
      pow2 = Q24_ONE;
      p = val;
    end else if (adam_reg != 0) begin
      if (idx == 0) begin
        pow1 = (pow1 * b1_reg) >> 24;
        pow2 = (pow2 * b2_reg) >> 24;
      end
      p = clamp32(longint'(par_mem[idx]) - adam_step(idx, val));
      par_mem[idx] = int'(p);
    end else begin
      v = (mom_reg * longint'(vel_mem[idx]) * 256 - lr_reg * val) >>> 24;
      v = clamp32(v);
      vel_mem[idx] = int'(v);
      p = clamp32(longint'(par_mem[idx]) + v);
      par_mem[idx] = int'(p);
    end
    u.idx = idx[9:0];
    u.par = p[31:0];
    u.sat = upd_sat;
    return u;
  endfunction

  function automatic void apply_cfg(smau_pkg::cfg_idx_t r, longint d);
    case (r)
      smau_pkg::CFG_LEARNING_RATE: begin
        lr_reg = d & 64'hFFFFFF;
        if (lr_reg == 0) lr_reg = 1;
      end
      smau_pkg::CFG_MOMENTUM: begin
        mom_reg = d & 64'h1FFFF;
        if (mom_reg > 65536) mom_reg = 65536;
      end
      smau_pkg::CFG_ADAM_ENABLE: adam_reg = d & 1;
      smau_pkg::CFG_BETA_FIRST: begin
        b1_reg = d & 64'h1FFFFFF;
        if (b1_reg > Q24_ONE) b1_reg = Q24_ONE;
      end
      smau_pkg::CFG_BETA_SECOND: begin
        b2_reg = d & 64'h1FFFFFF;
        if (b2_reg > Q24_ONE) b2_reg = Q24_ONE;
      end
      smau_pkg::CFG_EPSILON: eps_reg = d & 64'hFFFFFFFF;
      default: ;
    endcase
  endfunction

  // Compare every result transfer with the oldest expected update.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: index %0d param %h sat %b",
                   out_index, out_param_out, out_saturated);
      end else begin
        want = pending_updates.pop_front();
        if (out_index !== want.idx || out_param_out !== want.par ||
            out_saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected index %0d param %h sat %b, got %0d %h %b",
                     want.idx, want.par, want.sat,
                     out_index, out_param_out, out_saturated);
        end
      end
    end
  end

  // Send one command; returns at the edge where it transfers, start left high.
  task automatic send_item(smau_pkg::cmd_t cmd, int idx, int val);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_index   <= idx[9:0];
    in_value   <= val;
    do @(posedge clk); while (busy);
    pending_updates.push_back(predict_update(cmd, idx, longint'(val)));
    if (cmd == smau_pkg::CMD_LOAD) loaded[idx] = 1'b1;
  endtask

  // Stop sending and let every expected update come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all six registers while the block is idle.
  task automatic set_config(longint lr, longint mom, longint adam,
                            longint b1, longint b2, longint eps);
    longint vals[6];
    vals = '{lr, mom, adam, b1, b2, eps};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= smau_pkg::cfg_idx_t'(i);
      cfg_data  <= vals[i][31:0];
      @(posedge clk);
      apply_cfg(smau_pkg::cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_value();
    if ($urandom_range(3) == 0) return $urandom;
    return int'($urandom_range(262143)) - 131072;
  endfunction

  // Loads and gradients at the value extremes in SGD mode.
  task automatic test_sgd_extremes();
    send_item(smau_pkg::CMD_LOAD, 0, 32'h7FFFFFFF);
    send_item(smau_pkg::CMD_LOAD, 1023, 32'h80000000);
    send_item(smau_pkg::CMD_LOAD, 512, 0);
    send_item(smau_pkg::CMD_GRAD, 0, 32'h80000000);
    send_item(smau_pkg::CMD_GRAD, 1023, 32'h7FFFFFFF);
    send_item(smau_pkg::CMD_GRAD, 512, 1);
    send_item(smau_pkg::CMD_GRAD, 512, -1);
    send_item(smau_pkg::CMD_GRAD, 0, 0);
    drain();
  endtask

  // Adam corner cases: unity powers, the power advance and a zero root guard.
  task automatic test_adam_corners();
    set_config(smau_pkg::LR_RESET, smau_pkg::MOM_RESET, 1, smau_pkg::BETA1_RESET,
               smau_pkg::BETA2_RESET, smau_pkg::EPS_RESET);
    send_item(smau_pkg::CMD_GRAD, 512, 65536);
    send_item(smau_pkg::CMD_GRAD, 0, 65536);
    send_item(smau_pkg::CMD_GRAD, 1023, 32'h80000000);
    send_item(smau_pkg::CMD_GRAD, 512, 32'h7FFFFFFF);
    send_item(smau_pkg::CMD_LOAD, 5, -65536);
    send_item(smau_pkg::CMD_GRAD, 5, -65536);
    drain();
    set_config(smau_pkg::LR_RESET, smau_pkg::MOM_RESET, 1, smau_pkg::BETA1_RESET,
               smau_pkg::BETA2_RESET, 0);
    send_item(smau_pkg::CMD_LOAD, 0, 65536);
    send_item(smau_pkg::CMD_GRAD, 0, 0);
    send_item(smau_pkg::CMD_GRAD, 0, 16);
    send_item(smau_pkg::CMD_GRAD, 0, -16);
    drain();
  endtask

  // Random phase: mostly load-then-sweep sequences starting at element zero.
  task automatic test_random_phase(int idle_pct, int quota, longint lr, longint mom,
                                   longint adam, longint b1, longint b2, longint eps);
    int sent, k, sweeps, pick;
    int elems[$];
    sent = 0;
    drain();
    set_config(lr, mom, adam, b1, b2, eps);
    sender_idle_pct = idle_pct;
    while (sent < quota) begin
      if ($urandom_range(4) == 0) begin
        // Stray command: a load anywhere or a gradient on a loaded element.
        pick = $urandom_range(1023);
        if (loaded[pick] && $urandom_range(1))
          send_item(smau_pkg::CMD_GRAD, pick, rand_value());
        else send_item(smau_pkg::CMD_LOAD, pick, $urandom);
        sent++;
      end else begin
        elems = '{0};
        k = $urandom_range(1, 6);
        for (int i = 1; i < k; i++) elems.push_back($urandom_range(1, 1023));
        foreach (elems[i]) send_item(smau_pkg::CMD_LOAD, elems[i], rand_value());
        sweeps = $urandom_range(1, 4);
        for (int s = 0; s < sweeps; s++)
          foreach (elems[i]) send_item(smau_pkg::CMD_GRAD, elems[i], rand_value());
        sent += k * (sweeps + 1);
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= smau_pkg::CMD_LOAD;
    in_index   <= '0;
    in_value   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= smau_pkg::CFG_LEARNING_RATE;
    cfg_data   <= '0;
    mismatches = 0;
    sender_idle_pct = 25;
    pow1 = Q24_ONE;
    pow2 = Q24_ONE;
    lr_reg = smau_pkg::LR_RESET;
    mom_reg = smau_pkg::MOM_RESET;
    adam_reg = 0;
    b1_reg = smau_pkg::BETA1_RESET;
    b2_reg = smau_pkg::BETA2_RESET;
    eps_reg = smau_pkg::EPS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sgd_extremes();
    test_adam_corners();
    test_random_phase(25, 75, 24'hFFFFFF, 0, 0, smau_pkg::BETA1_RESET,
                      smau_pkg::BETA2_RESET, smau_pkg::EPS_RESET);
    test_random_phase(56, 75, 0, 32'h1FFFF, 0, smau_pkg::BETA1_RESET,
                      smau_pkg::BETA2_RESET, smau_pkg::EPS_RESET);
    test_random_phase(0, 75, $urandom_range(1, 16777215), 65536, 1,
                      smau_pkg::BETA1_RESET, smau_pkg::BETA2_RESET, $urandom);
    test_random_phase(25, 75, 24'hFFFFFF, $urandom_range(65536), 1,
                      0, 32'h1FFFFFF, 0);
    test_random_phase(56, 75, smau_pkg::LR_RESET, smau_pkg::MOM_RESET, 1, Q24_ONE, 0,
                      32'hFFFFFFFF);
    test_random_phase(0, 75, $urandom_range(1, 16777215), smau_pkg::MOM_RESET, 1,
                      $urandom_range(16777216), $urandom_range(16777216), $urandom);
    drain();

    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("sgd_momentum_adam_update_top test passed");
    end else begin
      $display("sgd_momentum_adam_update_top test failed");
    end
    $finish;
  end

endmodule
